[rtl/assert_macros.svh]
// Assertion macros shared by the RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock unless in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[rtl/mi4_pkg.sv]
// Package for the 4x4 matrix inverse: widths, index tables.
// No dependencies.
package mi4_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int EW = 32;
  localparam int SW = 66;
  localparam int DW = 134;
  localparam int AW = 100;

  function automatic logic [15:0] sub_pairs(input logic [3:0] i);
    case (i)
      4'd0: sub_pairs = {4'd0, 4'd5, 4'd1, 4'd4};
      4'd1: sub_pairs = {4'd0, 4'd6, 4'd2, 4'd4};
      4'd2: sub_pairs = {4'd0, 4'd7, 4'd3, 4'd4};
      4'd3: sub_pairs = {4'd1, 4'd6, 4'd2, 4'd5};
      4'd4: sub_pairs = {4'd1, 4'd7, 4'd3, 4'd5};
      4'd5: sub_pairs = {4'd2, 4'd7, 4'd3, 4'd6};
      4'd6: sub_pairs = {4'd8, 4'd13, 4'd9, 4'd12};
      4'd7: sub_pairs = {4'd8, 4'd14, 4'd10, 4'd12};
      4'd8: sub_pairs = {4'd8, 4'd15, 4'd11, 4'd12};
      4'd9: sub_pairs = {4'd9, 4'd14, 4'd10, 4'd13};
      4'd10: sub_pairs = {4'd9, 4'd15, 4'd11, 4'd13};
      4'd11: sub_pairs = {4'd10, 4'd15, 4'd11, 4'd14};
      default: sub_pairs = 16'd0;
    endcase
  endfunction

  // adjugate term: element, sub-determinant, positive
  function automatic logic [8:0] adj_term(input logic [3:0] k, input logic [1:0] j);
    logic [26:0] r;
    case (k)
      4'd0: r = {4'd5, 4'd11, 1'b1, 4'd6, 4'd10, 1'b0, 4'd7, 4'd9, 1'b1};
      4'd1: r = {4'd1, 4'd11, 1'b0, 4'd2, 4'd10, 1'b1, 4'd3, 4'd9, 1'b0};
      4'd2: r = {4'd13, 4'd5, 1'b1, 4'd14, 4'd4, 1'b0, 4'd15, 4'd3, 1'b1};
      4'd3: r = {4'd9, 4'd5, 1'b0, 4'd10, 4'd4, 1'b1, 4'd11, 4'd3, 1'b0};
      4'd4: r = {4'd4, 4'd11, 1'b0, 4'd6, 4'd8, 1'b1, 4'd7, 4'd7, 1'b0};
      4'd5: r = {4'd0, 4'd11, 1'b1, 4'd2, 4'd8, 1'b0, 4'd3, 4'd7, 1'b1};
      4'd6: r = {4'd12, 4'd5, 1'b0, 4'd14, 4'd2, 1'b1, 4'd15, 4'd1, 1'b0};
      4'd7: r = {4'd8, 4'd5, 1'b1, 4'd10, 4'd2, 1'b0, 4'd11, 4'd1, 1'b1};
      4'd8: r = {4'd4, 4'd10, 1'b1, 4'd5, 4'd8, 1'b0, 4'd7, 4'd6, 1'b1};
      4'd9: r = {4'd0, 4'd10, 1'b0, 4'd1, 4'd8, 1'b1, 4'd3, 4'd6, 1'b0};
      4'd10: r = {4'd12, 4'd4, 1'b1, 4'd13, 4'd2, 1'b0, 4'd15, 4'd0, 1'b1};
      4'd11: r = {4'd8, 4'd4, 1'b0, 4'd9, 4'd2, 1'b1, 4'd11, 4'd0, 1'b0};
      4'd12: r = {4'd4, 4'd9, 1'b0, 4'd5, 4'd7, 1'b1, 4'd6, 4'd6, 1'b0};
      4'd13: r = {4'd0, 4'd9, 1'b1, 4'd1, 4'd7, 1'b0, 4'd2, 4'd6, 1'b1};
      4'd14: r = {4'd12, 4'd3, 1'b0, 4'd13, 4'd1, 1'b1, 4'd14, 4'd0, 1'b0};
      default: r = {4'd8, 4'd3, 1'b1, 4'd9, 4'd1, 1'b0, 4'd10, 4'd0, 1'b1};
    endcase
    case (j)
      2'd0: adj_term = r[26:18];
      2'd1: adj_term = r[17:9];
      default: adj_term = r[8:0];
    endcase
  endfunction
endpackage

[rtl/mi4_ram.sv]
// Generic single-port-write, registered-read RAM.
// No dependencies.
module mi4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[rtl/mi4_div.sv]
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
// No dependencies.
module mi4_div #(
  parameter int NW = 132,
  parameter int DWID = 134
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [NW-1:0]   num,
  input  logic [DWID-1:0] den,
  output logic            busy,
  output logic [NW-1:0]   quo
);
  logic [NW-1:0]   q_r;
  logic [DWID-1:0] rem_r;
  logic [DWID-1:0] d_r;
  logic [$clog2(NW+1)-1:0] cnt_r;
  logic [DWID:0]   sh;
  logic [DWID:0]   diff;
  always_comb begin
    sh = {rem_r, q_r[NW-1]};
    diff = sh - {1'b0, d_r};
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      q_r <= num;
      rem_r <= '0;
      d_r <= den;
      cnt_r <= ($clog2(NW+1))'(NW);
    end else if (cnt_r != '0) begin
      if (sh >= {1'b0, d_r}) begin
        rem_r <= diff[DWID-1:0];
        q_r <= {q_r[NW-2:0], 1'b1};
      end else begin
        rem_r <= sh[DWID-1:0];
        q_r <= {q_r[NW-2:0], 1'b0};
      end
      cnt_r <= cnt_r - 1'b1;
    end
  end
  assign busy = (cnt_r != '0);
  assign quo = q_r;
endmodule

[rtl/matrix_inverse_4x4.sv]
// 4x4 matrix inverse by cofactors; sixteen elements in, sixteen results out.
// Results leave one at a time; the adjugate term and division for the next result start only
// after the previous result is taken (out_tready high). A whole matrix is finished before the
// next is accepted; the time per matrix is set by the bit-serial divider and the shared 32x32
// multiplier; in_tready is low from the 16th element on.
// Reset: rst_n synchronous; load count, sequencer and out_tvalid clear, RAM is not cleared.
`include "assert_macros.svh"
module matrix_inverse_4x4 #(
  parameter int FRAC_BITS = mi4_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // element_value[31:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // inverse_value[31:0], element_index[35:32], zeros
  output logic [1:0]  out_tuser,  // singular[0], saturated[1]
  output logic        out_tlast
);
  localparam int NW = mi4_pkg::AW + 2 * FRAC_BITS;
  localparam int DWW = mi4_pkg::DW;
  localparam int SW = mi4_pkg::SW;
  localparam int AWW = mi4_pkg::AW;

  typedef enum logic [3:0] {
    S_LOAD, S_SD_A, S_SD_B, S_SD_C, S_DET_A, S_DET_M, S_DET_C, S_DET_B,
    S_ADJ_A, S_ADJ_B, S_ADJ_M, S_ADJ_C, S_DIV, S_DIVW, S_OUT
  } state_t;

  state_t state_r;
  logic [4:0] cnt_r;
  logic [3:0] sidx_r;
  logic [1:0] tj_r;
  logic signed [31:0] a_r;
  logic signed [SW-1:0] sd_r [12];
  logic signed [SW-1:0] acc_sd_r;
  logic signed [DWW-1:0] det_r;
  logic signed [AWW-1:0] adj_r;
  logic signed [63:0] p32_r;
  logic [3:0] k_r;
  logic div_start;
  logic div_busy;
  logic [NW-1:0] quo;
  logic neg_r;
  logic [NW-1:0] num_w;
  logic [DWW-1:0] dmag_r;
  logic [31:0] val_r;
  logic sat_r, sing_r;
  logic [63:0] mul_a_r;
  logic [63:0] mul_b_r;
  logic mul_neg_r;
  logic [1:0] pp_r;
  logic [127:0] prod_r;

  logic [3:0] raddr;
  logic [31:0] rdata;
  logic [15:0] pr;
  logic [8:0] at;

  always_comb begin
    pr = mi4_pkg::sub_pairs(sidx_r);
    at = mi4_pkg::adj_term(k_r, tj_r);
    case (state_r)
      S_SD_A: raddr = (tj_r == 2'd0) ? pr[15:12] : pr[7:4];
      S_SD_B: raddr = (tj_r == 2'd0) ? pr[11:8] : pr[3:0];
      default: raddr = at[8:5];
    endcase
  end

  mi4_ram #(.WIDTH(32), .DEPTH(16)) u_ram (
    .clk(clk), .we(in_tvalid && in_tready), .waddr(cnt_r[3:0]), .wdata(in_tdata),
    .raddr(raddr), .rdata(rdata)
  );

  mi4_div #(.NW(NW), .DWID(DWW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(num_w), .den(dmag_r),
    .busy(div_busy), .quo(quo)
  );

  // det term: sd pair and sign, by step
  logic [3:0] da, db;
  logic dpos;
  always_comb begin
    case (sidx_r)
      4'd0: begin da = 4'd0; db = 4'd11; dpos = 1'b1; end
      4'd1: begin da = 4'd1; db = 4'd10; dpos = 1'b0; end
      4'd2: begin da = 4'd2; db = 4'd9;  dpos = 1'b1; end
      4'd3: begin da = 4'd3; db = 4'd8;  dpos = 1'b1; end
      4'd4: begin da = 4'd4; db = 4'd7;  dpos = 1'b0; end
      default: begin da = 4'd5; db = 4'd6; dpos = 1'b1; end
    endcase
  end

  // shared multiplier: magnitudes, one 32x32 partial product per cycle
  logic [SW-1:0] sd_da, sd_db, sd_at;
  logic [63:0] mag_da, mag_db, mag_at;
  logic [31:0] mag_el, pa, pb;
  logic [63:0] pp;
  logic [127:0] pp_sh;
  logic signed [AWW-1:0] adj_abs;
  always_comb begin
    sd_da = sd_r[da];
    sd_db = sd_r[db];
    sd_at = sd_r[at[4:1]];
    mag_da = sd_da[SW-1] ? 64'(-sd_da) : 64'(sd_da);
    mag_db = sd_db[SW-1] ? 64'(-sd_db) : 64'(sd_db);
    mag_at = sd_at[SW-1] ? 64'(-sd_at) : 64'(sd_at);
    mag_el = rdata[31] ? -rdata : rdata;
    pa = pp_r[0] ? mul_a_r[63:32] : mul_a_r[31:0];
    pb = pp_r[1] ? mul_b_r[63:32] : mul_b_r[31:0];
    pp = pa * pb;
    case (pp_r)
      2'd0: pp_sh = {64'd0, pp};
      2'd3: pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
    adj_abs = adj_r[AWW-1] ? -adj_r : adj_r;
  end

  assign in_tready = (state_r == S_LOAD);
  assign div_start = (state_r == S_DIV);
  assign num_w = NW'(adj_abs) << (2 * FRAC_BITS);

  logic big;
  always_comb big = neg_r ? (quo > NW'(33'h080000000)) : (quo > NW'(32'h7FFFFFFF));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r <= '0;
      out_tvalid <= 1'b0;
      sidx_r <= '0;
      tj_r <= '0;
      k_r <= '0;
    end else begin
      case (state_r)
        S_LOAD: if (in_tvalid) begin
          if (cnt_r == 5'd15) begin
            cnt_r <= '0;
            sidx_r <= '0;
            tj_r <= '0;
            state_r <= S_SD_A;
          end else cnt_r <= cnt_r + 1'b1;
        end
        S_SD_A: state_r <= S_SD_B;
        S_SD_B: begin a_r <= rdata; state_r <= S_SD_C; end
        S_SD_C: begin
          p32_r <= a_r * $signed(rdata);
          if (tj_r == 2'd0) begin
            tj_r <= 2'd1;
            state_r <= S_SD_A;
          end else begin
            tj_r <= 2'd2;
            state_r <= S_SD_A;
          end
          if (tj_r == 2'd1) acc_sd_r <= SW'(p32_r);
          if (tj_r == 2'd2) begin
            sd_r[sidx_r] <= acc_sd_r - SW'(p32_r);
            tj_r <= 2'd0;
            if (sidx_r == 4'd11) begin
              sidx_r <= '0;
              det_r <= '0;
              state_r <= S_DET_A;
            end else begin
              sidx_r <= sidx_r + 1'b1;
              state_r <= S_SD_A;
            end
          end else if (tj_r == 2'd1) begin
            state_r <= S_SD_A;
          end
        end
        S_DET_A: begin
          mul_a_r <= mag_da;
          mul_b_r <= mag_db;
          mul_neg_r <= sd_da[SW-1] ^ sd_db[SW-1] ^ ~dpos;
          prod_r <= '0;
          pp_r <= '0;
          state_r <= S_DET_M;
        end
        S_DET_M: begin
          prod_r <= prod_r + pp_sh;
          pp_r <= pp_r + 1'b1;
          if (pp_r == 2'd3) state_r <= S_DET_C;
        end
        S_DET_C: begin
          det_r <= mul_neg_r ? det_r - DWW'(prod_r) : det_r + DWW'(prod_r);
          if (sidx_r == 4'd5) state_r <= S_DET_B;
          else begin
            sidx_r <= sidx_r + 1'b1;
            state_r <= S_DET_A;
          end
        end
        S_DET_B: begin
          dmag_r <= det_r[DWW-1] ? DWW'(-det_r) : DWW'(det_r);
          k_r <= '0;
          tj_r <= '0;
          adj_r <= '0;
          state_r <= S_ADJ_A;
        end
        S_ADJ_A: state_r <= S_ADJ_B;
        S_ADJ_B: begin
          mul_a_r <= {32'd0, mag_el};
          mul_b_r <= mag_at;
          mul_neg_r <= rdata[31] ^ sd_at[SW-1] ^ ~at[0];
          prod_r <= '0;
          pp_r <= '0;
          state_r <= S_ADJ_M;
        end
        S_ADJ_M: begin
          prod_r <= prod_r + pp_sh;
          pp_r <= pp_r + 1'b1;
          if (pp_r == 2'd3) state_r <= S_ADJ_C;
        end
        S_ADJ_C: begin
          adj_r <= mul_neg_r ? adj_r - AWW'(prod_r) : adj_r + AWW'(prod_r);
          if (tj_r == 2'd2) begin
            tj_r <= '0;
            state_r <= S_DIV;
          end else begin
            tj_r <= tj_r + 1'b1;
            state_r <= S_ADJ_A;
          end
        end
        S_DIV: begin
          if (det_r == '0) begin
            sing_r <= 1'b1;
          end else begin
            sing_r <= 1'b0;
          end
          state_r <= S_DIVW;
        end
        S_DIVW: if (!div_busy) begin
          if (sing_r) begin
            val_r <= '0; sat_r <= 1'b0;
          end else if (big) begin
            sat_r <= 1'b1;
            val_r <= neg_r ? 32'h80000000 : 32'h7FFFFFFF;
          end else begin
            sat_r <= 1'b0;
            val_r <= neg_r ? 32'(-quo[31:0]) : quo[31:0];
          end
          out_tvalid <= 1'b1;
          state_r <= S_OUT;
        end
        S_OUT: if (out_tready) begin
          out_tvalid <= 1'b0;
          adj_r <= '0;
          if (k_r == 4'd15) state_r <= S_LOAD;
          else begin
            k_r <= k_r + 1'b1;
            state_r <= S_ADJ_A;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DIV) begin
      neg_r <= adj_r[AWW-1] ^ det_r[DWW-1];
    end
  end

  assign out_tdata = {4'd0, k_r, val_r};
  assign out_tuser = {sat_r, sing_r};
  assign out_tlast = (k_r == 4'd15);

  `ASSERT_IMPL(a_noin_busy, clk, rst_n, state_r != S_LOAD, !in_tready)
  `ASSERT_IMPL(a_out_state, clk, rst_n, out_tvalid, state_r == S_OUT)
  `ASSERT_NEXT(a_div_run, clk, rst_n, div_start, div_busy)
endmodule

[bench/tb_matrix_inverse_4x4.sv]
// Testbench for matrix_inverse_4x4: streams 4x4 matrices in, checks every inverse element
// against an exact cofactor predictor, under varied idling and a long output hold-off.
// Depends on rtl/mi4_pkg.sv and rtl/matrix_inverse_4x4.sv.
module tb_matrix_inverse_4x4;
  localparam int FB = mi4_pkg::FRAC_BITS_DEF;

  typedef struct {
    logic [31:0] value;
    logic [3:0]  index;
    logic        singular;
    logic        saturated;
    logic        last;
  } inverse_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  matrix_inverse_4x4 #(.FRAC_BITS(FB)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic signed [31:0] elements [16];
  int                 elem_count = 0;
  inverse_item_t      inverse_q [$];
  int                 mismatches = 0;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  int                 hold_requests = 0;
  int                 hold_served = 0;
  int                 hold_left = 0;

  // exact 3x3 minor of the held matrix, row r and column c removed
  function automatic logic signed [191:0] minor3(int r, int c);
    logic signed [191:0] a [3][3];
    int rr, cc;
    rr = 0;
    for (int i = 0; i < 4; i++) begin
      if (i == r) continue;
      cc = 0;
      for (int j = 0; j < 4; j++) begin
        if (j == c) continue;
        a[rr][cc] = elements[i*4+j];
        cc++;
      end
      rr++;
    end
    return a[0][0] * (a[1][1] * a[2][2] - a[1][2] * a[2][1])
         - a[0][1] * (a[1][0] * a[2][2] - a[1][2] * a[2][0])
         + a[0][2] * (a[1][0] * a[2][1] - a[1][1] * a[2][0]);
  endfunction

  function automatic logic signed [191:0] cofactor(int r, int c);
    return ((r + c) % 2) ? -minor3(r, c) : minor3(r, c);
  endfunction

  task automatic predict_inverse();
    logic signed [191:0] det, adj, quot, e;
    inverse_item_t res;
    det = '0;
    for (int j = 0; j < 4; j++) begin
      e = elements[j];
      det = det + e * cofactor(0, j);
    end
    for (int k = 0; k < 16; k++) begin
      res.index = k[3:0];
      res.last = (k == 15);
      res.singular = (det == 0);
      res.saturated = 1'b0;
      res.value = '0;
      if (det != 0) begin
        adj = cofactor(k % 4, k / 4);
        quot = (adj <<< (2 * FB)) / det;
        if (quot > 192'sd2147483647) begin
          res.value = 32'h7FFF_FFFF;
          res.saturated = 1'b1;
        end else if (quot < -192'sd2147483648) begin
          res.value = 32'h8000_0000;
          res.saturated = 1'b1;
        end else begin
          res.value = quot[31:0];
        end
      end
      inverse_q.push_back(res);
    end
  endtask

  task automatic send_element(logic [31:0] v);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= v;
    do @(posedge clk); while (!in_tready);
    elements[elem_count] = v;
    elem_count++;
    if (elem_count == 16) begin
      elem_count = 0;
      predict_inverse();
    end
  endtask

  task automatic send_matrix(logic [31:0] m [16]);
    for (int i = 0; i < 16; i++) send_element(m[i]);
  endtask

  // output side: random stalls plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left <= 3000;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    inverse_item_t exp_item;
    if (rst_n && out_tvalid && out_tready) begin
      if (inverse_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value %h index %0d",
                   out_tdata[31:0], out_tdata[35:32]);
      end else begin
        exp_item = inverse_q.pop_front();
        if (out_tdata[31:0] !== exp_item.value || out_tdata[35:32] !== exp_item.index ||
            out_tuser[0] !== exp_item.singular || out_tuser[1] !== exp_item.saturated ||
            out_tlast !== exp_item.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch exp: idx %0d val %h sing %b sat %b last %b",
                     exp_item.index, exp_item.value, exp_item.singular,
                     exp_item.saturated, exp_item.last);
            $display("         got: idx %0d val %h sing %b sat %b last %b",
                     out_tdata[35:32], out_tdata[31:0], out_tuser[0],
                     out_tuser[1], out_tlast);
          end
        end
      end
    end
  end

  task automatic test_directed();
    logic [31:0] m [16];
    // singular, with both extreme element values (rows 0 and 2 equal)
    for (int i = 0; i < 16; i++) m[i] = $urandom;
    m[0] = 32'h8000_0000; m[1] = 32'h7FFF_FFFF; m[2] = 32'hFFFF_FFFF; m[3] = 32'h0000_0001;
    for (int i = 0; i < 4; i++) m[8+i] = m[i];
    send_matrix(m);
    // tiny diagonal: quotients overflow both ways
    for (int i = 0; i < 16; i++) m[i] = '0;
    m[0] = 32'd1; m[5] = 32'hFFFF_FFFF; m[10] = 32'd1; m[15] = 32'h0001_0000;
    m[1] = 32'd1;
    send_matrix(m);
  endtask

  task automatic test_random(int count);
    logic [31:0] m [16];
    int kind;
    repeat (count) begin
      kind = $urandom_range(3);
      for (int i = 0; i < 16; i++) begin
        case (kind)
          0: m[i] = $urandom;
          1: m[i] = ((i % 5) == 0) ? 32'(($urandom_range(1, 8) << FB) + $urandom_range(65535))
                                   : 32'($signed($urandom_range(131071)) - 65536);
          2: m[i] = 32'($signed($urandom_range(1 << 20)) - (1 << 19));
          default: m[i] = ($urandom_range(1)) ? $urandom : 32'($urandom_range(7));
        endcase
      end
      if (kind == 2 && $urandom_range(1)) begin
        for (int i = 0; i < 4; i++) m[12+i] = m[4+i];
      end
      send_matrix(m);
    end
  endtask

  task automatic test_backpressure();
    logic [31:0] m [16];
    send_idle_pct = 0;
    hold_requests++;
    for (int j = 0; j < 2; j++) begin
      for (int i = 0; i < 16; i++) m[i] = $urandom;
      send_matrix(m);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(3);
    send_idle_pct = 64; recv_stall_pct = 0;
    test_random(2);
    send_idle_pct = 0; recv_stall_pct = 64;
    test_random(3);
    send_idle_pct = 32; recv_stall_pct = 32;
    test_random(2);
    test_backpressure();
    in_tvalid <= 1'b0;
    while (inverse_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0 && inverse_q.size() == 0) begin
      $display("tb_matrix_inverse_4x4: PASS");
    end else begin
      $display("tb_matrix_inverse_4x4: FAIL");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("tb_matrix_inverse_4x4: FAIL");
    $finish;
  end
endmodule
